/* rtl/core/hfc_pkg.sv */
package hfc_pkg;

  localparam int unsigned HUM_W  = 10;
  localparam int unsigned MIN_W  = 16;
  localparam int unsigned SUB_W  = 6;
  localparam int unsigned CIDX_W = 3;

  localparam logic [SUB_W-1:0] SUB_LAST = 6'd59;

  localparam logic [2:0] PROCESS_PERIOD_S = 3'd5;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_MODE = 2'd2;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_AUTO = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_TARGET  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BAND    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_MIN_ON  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_MAX_ON  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MIN_OFF = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_MAX_OFF = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_FORCE   = 3'd6;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_READ,
    KIND_MODE,
    KIND_NONE
  } hfc_kind_t;

  typedef struct packed {
    hfc_kind_t        kind;
    logic [HUM_W-1:0] hum;
    logic [1:0]       mode;
  } hfc_item_t;

  typedef struct packed {
    logic [HUM_W-1:0] target;
    logic [HUM_W-1:0] band;
    logic [MIN_W-1:0] min_on;
    logic [MIN_W-1:0] max_on;
    logic [MIN_W-1:0] min_off;
    logic [MIN_W-1:0] max_off;
    logic [MIN_W-1:0] force_to;
  } hfc_cfg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [MIN_W-1:0] mode_min;
    logic [SUB_W-1:0] mode_sub;
    logic             fan;
    logic [MIN_W-1:0] fan_min;
    logic [SUB_W-1:0] fan_sub;
    logic             relay;
    logic             recheck;
  } hfc_st_t;

  function automatic hfc_st_t hfc_set_fan(hfc_st_t s, logic on);
    hfc_st_t r;
    r = s;
    if (on != r.fan) begin
      r.fan     = on;
      r.fan_min = '0;
      r.fan_sub = '0;
    end
    return r;
  endfunction

  // one control pass; minutes are whole elapsed minutes, saturated
  function automatic hfc_st_t hfc_pass(hfc_st_t s, logic respect_min, hfc_cfg_t c,
                                       logic wet, logic dry);
    hfc_st_t r;
    logic    hold;
    logic    min_ok;
    r    = s;
    hold = 1'b0;
    min_ok = 1'b0;
    if (r.mode != MODE_AUTO) begin
      r = hfc_set_fan(r, r.mode == MODE_ON);
      if (r.mode_min >= c.force_to) begin
        r.mode     = MODE_AUTO;
        r.mode_min = '0;
        r.mode_sub = '0;
        r.recheck  = 1'b1;
      end
    end
    if (r.mode == MODE_AUTO) begin
      if (r.fan) begin
        min_ok = r.fan_min >= c.min_on;
        if (c.max_on != '0 && r.fan_min >= c.max_on) r = hfc_set_fan(r, 1'b0);
        if (respect_min && !min_ok) hold = 1'b1;
        else if (dry) r = hfc_set_fan(r, 1'b0);
      end else begin
        min_ok = r.fan_min >= c.min_off;
        if (c.max_off != '0 && r.fan_min >= c.max_off) r = hfc_set_fan(r, 1'b1);
        if (respect_min && !min_ok) hold = 1'b1;
        else if (wet) r = hfc_set_fan(r, 1'b1);
      end
    end
    if (!hold) r.relay = r.fan;
    return r;
  endfunction

endpackage

/* rtl/core/hfc_cfg.sv */
module hfc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [hfc_pkg::CIDX_W-1:0]   wr_idx,
  input  logic [hfc_pkg::MIN_W-1:0]    wr_data,
  output hfc_pkg::hfc_cfg_t            cfg
);
  import hfc_pkg::*;

  hfc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target   <= 10'd600;
      cfg_r.band     <= 10'd100;
      cfg_r.min_on   <= '0;
      cfg_r.max_on   <= '0;
      cfg_r.min_off  <= '0;
      cfg_r.max_off  <= '0;
      cfg_r.force_to <= 16'd60;
    end else if (wr_en) begin
      case (wr_idx)
        CFG_TARGET:  cfg_r.target   <= wr_data[HUM_W-1:0];
        CFG_BAND:    cfg_r.band     <= wr_data[HUM_W-1:0];
        CFG_MIN_ON:  cfg_r.min_on   <= wr_data;
        CFG_MAX_ON:  cfg_r.max_on   <= wr_data;
        CFG_MIN_OFF: cfg_r.min_off  <= wr_data;
        CFG_MAX_OFF: cfg_r.max_off  <= wr_data;
        CFG_FORCE:   cfg_r.force_to <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/hfc_front.sv */
module hfc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [hfc_pkg::HUM_W-1:0] in_hum,
  input  logic [1:0]           in_mode,
  output logic                 q_valid,
  input  logic                 q_ready,
  output hfc_pkg::hfc_item_t   q_item
);
  import hfc_pkg::*;

  hfc_item_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  hfc_item_t  dec;
  logic       push, pop;

  // classify the beat
  always_comb begin
    dec.hum  = in_hum;
    dec.mode = in_mode;
    case (in_op)
      OP_TICK: dec.kind = KIND_TICK;
      OP_READ: dec.kind = KIND_READ;
      OP_MODE: dec.kind = (in_mode == MODE_OFF || in_mode == MODE_ON ||
                           in_mode == MODE_AUTO) ? KIND_MODE : KIND_NONE;
      default: dec.kind = KIND_NONE;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue occupancy out of range");

endmodule

/* rtl/core/hfc_back.sv */
module hfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hfc_pkg::hfc_cfg_t  cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  hfc_pkg::hfc_item_t q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_data
);
  import hfc_pkg::*;

  hfc_st_t          st_r, st_nxt, st_inc;
  logic [HUM_W-1:0] hum_r, hum_nxt;
  logic             seen_r, seen_nxt;
  logic [2:0]       pc_r, pc_nxt;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             pop, wet, dry;
  logic [11:0]      h2, t2, t2_hi, h2_lo;

  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    hum_nxt  = (q_item.kind == KIND_READ) ? q_item.hum : hum_r;
    seen_nxt = seen_r || (q_item.kind == KIND_READ);
    h2    = {1'b0, hum_nxt, 1'b0};
    t2    = {1'b0, cfg.target, 1'b0};
    t2_hi = t2 + {2'b00, cfg.band};
    h2_lo = h2 + {2'b00, cfg.band};
    wet   = seen_nxt && (h2 > t2_hi);
    dry   = seen_nxt && (h2_lo <= t2);

    st_inc = st_r;
    if (st_inc.mode_min != '1) begin
      if (st_inc.mode_sub == SUB_LAST) begin
        st_inc.mode_sub = '0;
        st_inc.mode_min = st_inc.mode_min + 16'd1;
      end else st_inc.mode_sub = st_inc.mode_sub + 6'd1;
    end
    if (st_inc.fan_min != '1) begin
      if (st_inc.fan_sub == SUB_LAST) begin
        st_inc.fan_sub = '0;
        st_inc.fan_min = st_inc.fan_min + 16'd1;
      end else st_inc.fan_sub = st_inc.fan_sub + 6'd1;
    end

    st_nxt = st_r;
    pc_nxt = pc_r;
    case (q_item.kind)
      KIND_TICK: begin
        st_nxt = st_inc;
        if (st_nxt.recheck) begin
          st_nxt.recheck = 1'b0;
          st_nxt = hfc_pass(st_nxt, 1'b0, cfg, wet, dry);
        end
        pc_nxt = pc_r + 3'd1;
        if (pc_nxt >= PROCESS_PERIOD_S) begin
          pc_nxt = '0;
          st_nxt = hfc_pass(st_nxt, 1'b1, cfg, wet, dry);
        end
      end
      KIND_READ: begin
        if (!seen_r) st_nxt = hfc_pass(st_r, 1'b0, cfg, wet, dry);
      end
      KIND_MODE: begin
        if (q_item.mode != st_r.mode) begin
          st_nxt.mode     = q_item.mode;
          st_nxt.mode_min = '0;
          st_nxt.mode_sub = '0;
          st_nxt = hfc_pass(st_nxt, 1'b0, cfg, wet, dry);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{mode: MODE_AUTO, default: '0};
      hum_r       <= '0;
      seen_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        st_r   <= st_nxt;
        hum_r  <= hum_nxt;
        seen_r <= seen_nxt;
        pc_r   <= pc_nxt;
      end
      if (pop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= {3'b000, seen_nxt, st_nxt.mode, st_nxt.fan, st_nxt.relay};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_forced_fan: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode != MODE_AUTO |-> st_r.fan == (st_r.mode == MODE_ON))
    else $error("forced mode with mismatched fan decision");

  a_forced_relay: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode != MODE_AUTO |-> st_r.relay == st_r.fan)
    else $error("forced mode with relay not following fan");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fan_sub <= SUB_LAST && st_r.mode_sub <= SUB_LAST)
    else $error("seconds-in-minute counter out of range");

endmodule

/* rtl/core/humidity_fan_controller_core.sv */
// Fan relay controller: every accepted input beat (tick, humidity reading or mode
// command) yields exactly one result beat with relay drive, fan decision, mode and
// reading-seen flag. One beat per cycle is sustained while the output is not stalled;
// a result passes from the two-entry front queue through the state update of the
// back end, which fills the output register.
// Configuration writes are always ready and must only be issued while idle.
module humidity_fan_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // humidity_reading[9:0], new_mode[11:10], zero[15:12]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // relay_on[0], fan_state[1], current_mode[3:2],
                                  // humidity_valid[4], zero[7:5]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hfc_pkg::*;

  hfc_cfg_t  cfg;
  hfc_item_t q_item;
  logic      q_valid, q_ready;

  assign cfg_ready = 1'b1;

  hfc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  hfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_hum   (in_tdata[9:0]),
    .in_mode  (in_tdata[11:10]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  hfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

/* sim/humidity_fan_controller_core_tb.sv */
`timescale 1ns / 1ps

import hfc_pkg::*;

typedef struct packed {
  logic       seen;
  logic [1:0] mode;
  logic       fan;
  logic       relay;
} fan_status_t;

class fan_relay_board;
  logic [9:0]  target_rh;
  logic [9:0]  band_rh;
  logic [15:0] min_on_m;
  logic [15:0] max_on_m;
  logic [15:0] min_off_m;
  logic [15:0] max_off_m;
  logic [15:0] force_m;

  logic [1:0]  mode;
  logic [31:0] mode_secs;
  logic        fan;
  logic [31:0] fan_secs;
  logic        relay;
  logic [9:0]  hum_rh;
  logic        seen;
  logic        recheck;
  logic [2:0]  period;

  fan_status_t status_q[$];
  int          errors;
  int          n_ticks;
  int          n_reads;
  int          n_cmds;
  int          n_other;
  int          n_checked;
  int          n_timeouts;

  function new();
    target_rh = 10'd600;
    band_rh   = 10'd100;
    min_on_m  = '0;
    max_on_m  = '0;
    min_off_m = '0;
    max_off_m = '0;
    force_m   = 16'd60;
    mode      = MODE_AUTO;
    mode_secs = '0;
    fan       = 1'b0;
    fan_secs  = '0;
    relay     = 1'b0;
    hum_rh    = '0;
    seen      = 1'b0;
    recheck   = 1'b0;
    period    = '0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_TARGET:  target_rh = val[9:0];
      CFG_BAND:    band_rh   = val[9:0];
      CFG_MIN_ON:  min_on_m  = val;
      CFG_MAX_ON:  max_on_m  = val;
      CFG_MIN_OFF: min_off_m = val;
      CFG_MAX_OFF: max_off_m = val;
      CFG_FORCE:   force_m   = val;
      default: ;
    endcase
  endfunction

  function void set_fan(logic on);
    if (on != fan) begin
      fan      = on;
      fan_secs = '0;
    end
  endfunction

  function void set_mode(logic [1:0] m);
    if (m != mode) begin
      mode      = m;
      mode_secs = '0;
    end
  endfunction

  function void run_pass(bit respect_min);
    int          h2;
    int          t2;
    int          b;
    bit          wet;
    bit          dry;
    bit          min_ok;
    logic [31:0] mins;
    h2  = 2 * int'(hum_rh);
    t2  = 2 * int'(target_rh);
    b   = int'(band_rh);
    wet = seen && (h2 > t2 + b);
    dry = seen && (h2 <= t2 - b);
    if (mode != MODE_AUTO) begin
      set_fan(mode == MODE_ON);
      if ({32'd0, mode_secs} >= 64'(force_m) * 64'd60) begin
        set_mode(MODE_AUTO);
        recheck = 1'b1;
        n_timeouts++;
      end
    end
    if (mode == MODE_AUTO) begin
      mins = fan_secs / 32'd60;
      if (fan) begin
        min_ok = mins >= 32'(min_on_m);
        if (max_on_m != '0 && mins >= 32'(max_on_m)) set_fan(1'b0);
        if (respect_min && !min_ok) return;
        if (dry) set_fan(1'b0);
      end else begin
        min_ok = mins >= 32'(min_off_m);
        if (max_off_m != '0 && mins >= 32'(max_off_m)) set_fan(1'b1);
        if (respect_min && !min_ok) return;
        if (wet) set_fan(1'b1);
      end
    end
    relay = fan;
  endfunction

  function void take_input(logic [1:0] op, logic [9:0] hum, logic [1:0] nm);
    case (op)
      OP_TICK: begin
        n_ticks++;
        if (mode_secs != '1) mode_secs = mode_secs + 32'd1;
        if (fan_secs != '1) fan_secs = fan_secs + 32'd1;
        if (recheck) begin
          recheck = 1'b0;
          run_pass(1'b0);
        end
        period = period + 3'd1;
        if (period >= PROCESS_PERIOD_S) begin
          period = '0;
          run_pass(1'b1);
        end
      end
      OP_READ: begin
        n_reads++;
        hum_rh = hum;
        if (!seen) begin
          seen = 1'b1;
          run_pass(1'b0);
        end
      end
      OP_MODE: begin
        n_cmds++;
        if (nm <= MODE_AUTO && nm != mode) begin
          set_mode(nm);
          run_pass(1'b0);
        end
      end
      default: n_other++;
    endcase
    status_q.push_back('{seen, mode, fan, relay});
  endfunction

  function void compare_result(logic [7:0] d);
    fan_status_t want;
    if (status_q.size() == 0) begin
      $error("result beat %h arrived with no expectation waiting", d);
      errors++;
      return;
    end
    want = status_q.pop_front();
    n_checked++;
    if (d[0] !== want.relay) begin
      $error("relay_on: expected %0d, got %0d", want.relay, d[0]);
      errors++;
    end
    if (d[1] !== want.fan) begin
      $error("fan_state: expected %0d, got %0d", want.fan, d[1]);
      errors++;
    end
    if (d[3:2] !== want.mode) begin
      $error("current_mode: expected %0d, got %0d", want.mode, d[3:2]);
      errors++;
    end
    if (d[4] !== want.seen) begin
      $error("humidity_valid: expected %0d, got %0d", want.seen, d[4]);
      errors++;
    end
  endfunction

  function int pending();
    return status_q.size();
  endfunction
endclass

module humidity_fan_controller_core_tb;

  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam logic [1:0] OP_UNKNOWN   = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // humidity_reading[9:0], new_mode[11:10], zero[15:12]
  logic [1:0]  in_tuser;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // relay_on[0], fan_state[1], current_mode[3:2],
                           // humidity_valid[4], zero[7:5]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int unsigned snd_idle_pct = 23;
  int unsigned rcv_idle_pct = 84;
  int          phase_no     = 0;
  bit          held_off     = 1'b0;

  fan_relay_board board = new();

  humidity_fan_controller_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.take_input(in_tuser, in_tdata[9:0], in_tdata[11:10]);
      if (out_tvalid && out_tready) board.compare_result(out_tdata);
    end
  end

  // hold off once for a long stretch while the sender keeps offering
  initial begin : result_sink
    int unsigned n;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_no == 4 && in_tvalid && !held_off) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        for (n = 0; n < 64; n++) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(logic [1:0] op, logic [9:0] hum, logic [1:0] nm);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, nm, hum};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_cfg(int target, int band, int min_on, int max_on,
                           int min_off, int max_off, int force_to);
    logic [15:0] vals[7];
    int          i;
    vals = '{16'(target), 16'(band), 16'(min_on), 16'(max_on),
             16'(min_off), 16'(max_off), 16'(force_to)};
    for (i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.set_reg(3'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int k;
    in_tvalid <= 1'b0;
    @(posedge clk);
    for (k = 0; k < 20000 && board.pending() != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_item(bit with_reads);
    int unsigned r;
    int          lim;
    r = $urandom_range(99);
    if (r < 84 || (r < 92 && !with_reads)) begin
      send_item(OP_TICK, 10'($urandom), 2'($urandom));
    end else if (r < 92) begin
      if ($urandom_range(1)) begin
        lim = $urandom_range(1) ? (2 * int'(board.target_rh) + int'(board.band_rh)) / 2
                                : (2 * int'(board.target_rh) - int'(board.band_rh)) / 2;
        lim = lim + int'($urandom_range(6)) - 3;
        if (lim < 0) lim = 0;
        if (lim > 1023) lim = 1023;
      end else begin
        lim = $urandom_range(1023);
      end
      send_item(OP_READ, 10'(lim), 2'($urandom));
    end else if (r < 98) begin
      send_item(OP_MODE, 10'($urandom), 2'($urandom_range(3)));
    end else begin
      send_item(OP_UNKNOWN, 10'($urandom), 2'($urandom));
    end
  endtask

  task automatic run_phase(int no, int unsigned snd, int unsigned rcv, bit with_reads,
                           int n_items, int target, int band, int min_on, int max_on,
                           int min_off, int max_off, int force_to);
    int i;
    wait_idle();
    phase_no     = no;
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    write_cfg(target, band, min_on, max_on, min_off, max_off, force_to);
    send_item(OP_MODE, 10'($urandom), $urandom_range(1) ? MODE_ON : MODE_OFF);
    for (i = 0; i < n_items; i++) random_item(with_reads);
  endtask

  initial begin : stimulus
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_TICK, 10'd0, 2'd0);
    send_item(OP_MODE, 10'd0, MODE_OFF);
    send_item(OP_MODE, 10'd0, MODE_OFF);
    send_item(OP_MODE, 10'd0, MODE_UNKNOWN);
    send_item(OP_UNKNOWN, 10'h3ff, MODE_UNKNOWN);
    send_item(OP_MODE, 10'd0, MODE_ON);
    send_item(OP_MODE, 10'd0, MODE_AUTO);

    // no reading yet: only mode commands and the maximum times move the fan
    run_phase(0, 23, 84, 1'b0, 70, 600, 100, 0, 1, 0, 1, 60);

    wait_idle();
    write_cfg(600, 100, 0, 0, 0, 0, 60);
    send_item(OP_READ, 10'd1023, 2'd3);
    send_item(OP_READ, 10'd0, 2'd0);
    repeat (5) send_item(OP_TICK, 10'd0, 2'd0);
    send_item(OP_READ, 10'd650, 2'd0);
    repeat (5) send_item(OP_TICK, 10'd0, 2'd0);
    send_item(OP_READ, 10'd651, 2'd0);
    repeat (5) send_item(OP_TICK, 10'd0, 2'd0);

    run_phase(1, 23, 84, 1'b1, 80, 600, 100, 0, 0, 0, 0, 1);
    run_phase(2, 23, 84, 1'b1, 50, 0, 0, 1, 1, 1, 1, 0);
    run_phase(3, 84, 23, 1'b1, 50, 1000, 1000, 0, 1, 0, 1, 2);
    run_phase(4, 0, 0, 1'b1, 60, 500, 1, 65535, 65535, 65535, 65535, 65535);
    run_phase(5, 0, 0, 1'b1, 80, 301, 7, 1, 0, 0, 1, 1);
    run_phase(6, 0, 0, 1'b1, 50, 1023, 1023, 0, 0, 0, 0, 0);

    wait_idle();
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.errors++;
    end
    $display("Covered %0d ticks, %0d readings, %0d mode commands, %0d unknown ops",
             board.n_ticks, board.n_reads, board.n_cmds, board.n_other);
    $display("over 8 register settings; %0d result beats compared, %0d forced-mode expiries",
             board.n_checked, board.n_timeouts);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
